>>> sv/vcrp_pkg.sv
// Shared types, codes and a section helper for the voxel chunk record parser.
package vcrp_pkg;

    typedef enum logic [4:0] {
        PH_CX           = 5'd0,
        PH_CY           = 5'd1,
        PH_CZ           = 5'd2,
        PH_BTYPE        = 5'd3,
        PH_BSTR_LEN     = 5'd4,
        PH_BSTR_BYTES   = 5'd5,
        PH_PAL_SIZE     = 5'd6,
        PH_PAL_LEN      = 5'd7,
        PH_PAL_BYTES    = 5'd8,
        PH_BL_LTYPE_BLK = 5'd9,
        PH_BLK_SKIP     = 5'd10,
        PH_SKY_TYPE     = 5'd11,
        PH_SKY_SKIP     = 5'd12,
        PH_SKY_SINGLE   = 5'd13,
        PH_SKY_LTYPE    = 5'd14,
        PH_LIT_TYPE     = 5'd15,
        PH_LIT_LTYPE    = 5'd16,
        PH_LIT_SKIP     = 5'd17,
        PH_ENT_FLAG     = 5'd18,
        PH_ENT_SIZE     = 5'd19,
        PH_ENT_BYTES    = 5'd20
    } phase_t;

    localparam logic [2:0] SEC_COORD  = 3'd0;
    localparam logic [2:0] SEC_BLOCK  = 3'd1;
    localparam logic [2:0] SEC_SKY    = 3'd2;
    localparam logic [2:0] SEC_LIGHT  = 3'd3;
    localparam logic [2:0] SEC_ENTITY = 3'd4;

    localparam logic [3:0] ST_OK            = 4'd0;
    localparam logic [3:0] ST_BAD_BLOCK     = 4'd1;
    localparam logic [3:0] ST_BAD_BLK_LAYER = 4'd2;
    localparam logic [3:0] ST_BAD_SKY       = 4'd3;
    localparam logic [3:0] ST_BAD_SKY_LAYER = 4'd4;
    localparam logic [3:0] ST_BAD_LIGHT     = 4'd5;
    localparam logic [3:0] ST_BAD_LIT_LAYER = 4'd6;
    localparam logic [3:0] ST_BAD_ENTITY    = 4'd7;
    localparam logic [3:0] ST_HALTED        = 4'd8;

    localparam logic [7:0] BT_NULL    = 8'd0;
    localparam logic [7:0] BT_SINGLE  = 8'd1;
    localparam logic [7:0] BT_PALETTE = 8'd2;

    localparam logic [7:0] BL_ONE     = 8'd1;
    localparam logic [7:0] BL_FOUR    = 8'd2;
    localparam logic [7:0] BL_QUARTER = 8'd3;
    localparam logic [7:0] BL_HALF    = 8'd4;
    localparam logic [7:0] BL_FULL    = 8'd5;
    localparam logic [7:0] BL_DOUBLE  = 8'd6;
    localparam logic [7:0] BL_EIGHTH  = 8'd7;

    localparam logic [7:0] SKY_NULL    = 8'd1;
    localparam logic [7:0] SKY_LAYERED = 8'd2;
    localparam logic [7:0] SKY_SINGLE  = 8'd3;
    localparam logic [7:0] SKYL_ONE    = 8'd1;
    localparam logic [7:0] SKYL_HALF   = 8'd2;

    localparam logic [7:0] LIT_NULL    = 8'd1;
    localparam logic [7:0] LIT_LAYERED = 8'd2;
    localparam logic [7:0] LITL_THREE  = 8'd1;
    localparam logic [7:0] LITL_DOUBLE = 8'd2;
    localparam logic [7:0] LITL_MIX_LO = 8'd3;
    localparam logic [7:0] LITL_MIX_HI = 8'd5;

    localparam logic [7:0] ENT_NONE = 8'd0;
    localparam logic [7:0] ENT_BLOB = 8'd1;

    typedef struct packed {
        logic [7:0]         byte_echo;
        logic [2:0]         section;
        logic               record_last;
        logic [3:0]         status;
        logic signed [31:0] chunk_x;
        logic signed [31:0] chunk_y;
        logic signed [31:0] chunk_z;
    } result_t;

    function automatic logic [2:0] section_of(input phase_t ph);
        logic [2:0] sec;
        if (ph <= PH_CZ)
            sec = SEC_COORD;
        else if (ph <= PH_BLK_SKIP)
            sec = SEC_BLOCK;
        else if (ph <= PH_SKY_LTYPE)
            sec = SEC_SKY;
        else if (ph <= PH_LIT_SKIP)
            sec = SEC_LIGHT;
        else
            sec = SEC_ENTITY;
        return sec;
    endfunction

endpackage

>>> sv/voxel_chunk_record_parser_top.sv
// Voxel chunk record parser: byte-wise section tagging, coordinate capture, error halt.
// Takes one byte per cycle while in_stall is low and returns one result per byte: the
// byte itself, the record section it belongs to, a last flag on the byte that closes a
// record together with the captured x/y/z coordinates, and a status code. Each byte
// passes through one phase register update and one result register, so the sustained
// rate is one byte per clock while out_stall is low; a two-entry output buffer takes
// one more byte while a result waits. An unknown type byte is reported once with its
// error code, after which every byte is echoed with status halted until reset.
module voxel_chunk_record_parser_top #(
    parameter int LAYERS      = 16,
    parameter int LAYER_CELLS = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         data_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         byte_echo,
    output logic [2:0]         section,
    output logic               record_last,
    output logic [3:0]         status,
    output logic signed [31:0] chunk_x,
    output logic signed [31:0] chunk_y,
    output logic signed [31:0] chunk_z
);
    import vcrp_pkg::*;

    localparam int LCW = (LAYERS > 1) ? $clog2(LAYERS) : 1;
    localparam logic [LCW-1:0] LAYER_LAST = LCW'(LAYERS - 1);

    localparam logic [30:0] LEN_ONE     = 31'd1;
    localparam logic [30:0] LEN_THREE   = 31'd3;
    localparam logic [30:0] LEN_FOUR    = 31'd4;
    localparam logic [30:0] LEN_EIGHTH  = 31'(LAYER_CELLS / 8);
    localparam logic [30:0] LEN_QUARTER = 31'(LAYER_CELLS / 4);
    localparam logic [30:0] LEN_HALF    = 31'(LAYER_CELLS / 2);
    localparam logic [30:0] LEN_FULL    = 31'(LAYER_CELLS);
    localparam logic [30:0] LEN_DOUBLE  = 31'(LAYER_CELLS * 2);
    localparam logic [30:0] LEN_MIX     = 31'(3 + LAYER_CELLS / 2);

    phase_t             phase_reg, phase_next;
    logic [LCW-1:0]     layer_reg, layer_next;
    logic [30:0]        pal_reg, pal_next;
    logic [30:0]        skip_reg, skip_next;
    logic [31:0]        word_reg, word_next;
    logic [1:0]         idx_reg, idx_next;
    logic [31:0]        cx_reg, cx_next;
    logic [31:0]        cy_reg, cy_next;
    logic [31:0]        cz_reg, cz_next;
    logic               halted_reg, halted_next;

    result_t            res_c;
    result_t            out_reg, out_next;
    result_t            skid_reg, skid_next;
    logic               out_valid_reg, out_valid_next;
    logic               skid_valid_reg, skid_valid_next;

    logic               in_fire;
    logic               out_fire;
    logic [31:0]        word_shift;
    logic               word_done;
    logic               wlen_zero;
    logic [30:0]        wlen;
    logic               skip_end;
    logic               pal_end;
    logic               layer_end;
    logic [30:0]        blk_len;
    logic [30:0]        lit_len;

    assign in_stall  = skid_valid_reg;
    assign in_fire   = in_valid && !skid_valid_reg;
    assign out_fire  = out_valid_reg && !out_stall;

    assign word_shift = {word_reg[23:0], data_byte};
    assign word_done  = (idx_reg == 2'd3);
    assign wlen_zero  = word_shift[31] || (word_shift == 32'd0);
    assign wlen       = word_shift[30:0];
    assign skip_end   = (skip_reg == 31'd1);
    assign pal_end    = (pal_reg == 31'd1);
    assign layer_end  = (layer_reg == LAYER_LAST);

    always_comb
    begin
        case (data_byte)
            BL_ONE:     blk_len = LEN_ONE;
            BL_FOUR:    blk_len = LEN_FOUR;
            BL_QUARTER: blk_len = LEN_QUARTER;
            BL_HALF:    blk_len = LEN_HALF;
            BL_FULL:    blk_len = LEN_FULL;
            BL_DOUBLE:  blk_len = LEN_DOUBLE;
            BL_EIGHTH:  blk_len = LEN_EIGHTH;
            default:    blk_len = 31'd0;
        endcase
    end

    always_comb
    begin
        case (data_byte) inside
            LITL_THREE:                 lit_len = LEN_THREE;
            LITL_DOUBLE:                lit_len = LEN_DOUBLE;
            [LITL_MIX_LO:LITL_MIX_HI]:  lit_len = LEN_MIX;
            default:                    lit_len = 31'd0;
        endcase
    end

    // Result of the byte at the input
    always_comb
    begin
        res_c             = '0;
        res_c.byte_echo   = data_byte;
        res_c.section     = section_of(phase_reg);
        res_c.record_last = 1'b0;
        res_c.status      = ST_OK;
        if (halted_reg)
        begin
            res_c.section = SEC_COORD;
            res_c.status  = ST_HALTED;
        end
        else
        begin
            unique case (phase_reg) inside
                PH_BTYPE:
                    if (data_byte != BT_NULL && data_byte != BT_SINGLE &&
                        data_byte != BT_PALETTE)
                        res_c.status = ST_BAD_BLOCK;
                PH_BL_LTYPE_BLK:
                    if (blk_len == 31'd0)
                        res_c.status = ST_BAD_BLK_LAYER;
                PH_SKY_TYPE:
                    if (data_byte != SKY_NULL && data_byte != SKY_LAYERED &&
                        data_byte != SKY_SINGLE)
                        res_c.status = ST_BAD_SKY;
                PH_SKY_LTYPE:
                    if (data_byte != SKYL_ONE && data_byte != SKYL_HALF)
                        res_c.status = ST_BAD_SKY_LAYER;
                PH_LIT_TYPE:
                    if (data_byte != LIT_NULL && data_byte != LIT_LAYERED)
                        res_c.status = ST_BAD_LIGHT;
                PH_LIT_LTYPE:
                    if (lit_len == 31'd0)
                        res_c.status = ST_BAD_LIT_LAYER;
                PH_ENT_FLAG:
                    if (data_byte == ENT_NONE)
                        res_c.record_last = 1'b1;
                    else if (data_byte != ENT_BLOB)
                        res_c.status = ST_BAD_ENTITY;
                PH_ENT_SIZE:
                    res_c.record_last = word_done && wlen_zero;
                PH_ENT_BYTES:
                    res_c.record_last = skip_end;
                default:
                    res_c.record_last = 1'b0;
            endcase
            if (res_c.record_last)
            begin
                res_c.chunk_x = cx_reg;
                res_c.chunk_y = cy_reg;
                res_c.chunk_z = cz_reg;
            end
        end
    end

    // Parser state advance
    always_comb
    begin
        phase_next  = phase_reg;
        layer_next  = layer_reg;
        pal_next    = pal_reg;
        skip_next   = skip_reg;
        word_next   = word_reg;
        idx_next    = idx_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        cz_next     = cz_reg;
        halted_next = halted_reg;
        if (!halted_reg)
        begin
            unique case (phase_reg) inside
                PH_CX, PH_CY, PH_CZ, PH_BSTR_LEN, PH_PAL_SIZE, PH_PAL_LEN, PH_ENT_SIZE:
                begin
                    word_next = word_shift;
                    idx_next  = idx_reg + 2'd1;
                end
                default:
                begin
                    word_next = word_reg;
                end
            endcase

            unique case (phase_reg)
                PH_CX:
                    if (word_done)
                    begin
                        cx_next    = word_shift;
                        phase_next = PH_CY;
                    end
                PH_CY:
                    if (word_done)
                    begin
                        cy_next    = word_shift;
                        phase_next = PH_CZ;
                    end
                PH_CZ:
                    if (word_done)
                    begin
                        cz_next    = word_shift;
                        phase_next = PH_BTYPE;
                    end
                PH_BTYPE:
                    if (data_byte == BT_NULL)
                        phase_next = PH_SKY_TYPE;
                    else if (data_byte == BT_SINGLE)
                        phase_next = PH_BSTR_LEN;
                    else if (data_byte == BT_PALETTE)
                        phase_next = PH_PAL_SIZE;
                PH_BSTR_LEN:
                    if (word_done)
                    begin
                        if (wlen_zero)
                            phase_next = PH_SKY_TYPE;
                        else
                        begin
                            skip_next  = wlen;
                            phase_next = PH_BSTR_BYTES;
                        end
                    end
                PH_BSTR_BYTES:
                begin
                    skip_next = skip_reg - 31'd1;
                    if (skip_end)
                        phase_next = PH_SKY_TYPE;
                end
                PH_PAL_SIZE:
                    if (word_done)
                    begin
                        layer_next = '0;
                        if (wlen_zero)
                            phase_next = PH_BL_LTYPE_BLK;
                        else
                        begin
                            pal_next   = wlen;
                            phase_next = PH_PAL_LEN;
                        end
                    end
                PH_PAL_LEN:
                    if (word_done)
                    begin
                        if (wlen_zero)
                        begin
                            pal_next = pal_reg - 31'd1;
                            if (pal_end)
                            begin
                                layer_next = '0;
                                phase_next = PH_BL_LTYPE_BLK;
                            end
                            else
                                phase_next = PH_PAL_LEN;
                        end
                        else
                        begin
                            skip_next  = wlen;
                            phase_next = PH_PAL_BYTES;
                        end
                    end
                PH_PAL_BYTES:
                begin
                    skip_next = skip_reg - 31'd1;
                    if (skip_end)
                    begin
                        pal_next = pal_reg - 31'd1;
                        if (pal_end)
                        begin
                            layer_next = '0;
                            phase_next = PH_BL_LTYPE_BLK;
                        end
                        else
                            phase_next = PH_PAL_LEN;
                    end
                end
                PH_BL_LTYPE_BLK:
                    if (blk_len != 31'd0)
                    begin
                        skip_next  = blk_len;
                        phase_next = PH_BLK_SKIP;
                    end
                PH_BLK_SKIP:
                begin
                    skip_next = skip_reg - 31'd1;
                    if (skip_end)
                    begin
                        if (layer_end)
                        begin
                            layer_next = '0;
                            phase_next = PH_SKY_TYPE;
                        end
                        else
                        begin
                            layer_next = layer_reg + LCW'(1);
                            phase_next = PH_BL_LTYPE_BLK;
                        end
                    end
                end
                PH_SKY_TYPE:
                    if (data_byte == SKY_NULL)
                        phase_next = PH_LIT_TYPE;
                    else if (data_byte == SKY_SINGLE)
                        phase_next = PH_SKY_SINGLE;
                    else if (data_byte == SKY_LAYERED)
                    begin
                        layer_next = '0;
                        phase_next = PH_SKY_LTYPE;
                    end
                PH_SKY_SINGLE:
                    phase_next = PH_LIT_TYPE;
                PH_SKY_LTYPE:
                    if (data_byte == SKYL_ONE)
                    begin
                        skip_next  = LEN_ONE;
                        phase_next = PH_SKY_SKIP;
                    end
                    else if (data_byte == SKYL_HALF)
                    begin
                        skip_next  = LEN_HALF;
                        phase_next = PH_SKY_SKIP;
                    end
                PH_SKY_SKIP:
                begin
                    skip_next = skip_reg - 31'd1;
                    if (skip_end)
                    begin
                        if (layer_end)
                        begin
                            layer_next = '0;
                            phase_next = PH_LIT_TYPE;
                        end
                        else
                        begin
                            layer_next = layer_reg + LCW'(1);
                            phase_next = PH_SKY_LTYPE;
                        end
                    end
                end
                PH_LIT_TYPE:
                    if (data_byte == LIT_NULL)
                        phase_next = PH_ENT_FLAG;
                    else if (data_byte == LIT_LAYERED)
                    begin
                        layer_next = '0;
                        phase_next = PH_LIT_LTYPE;
                    end
                PH_LIT_LTYPE:
                    if (lit_len != 31'd0)
                    begin
                        skip_next  = lit_len;
                        phase_next = PH_LIT_SKIP;
                    end
                PH_LIT_SKIP:
                begin
                    skip_next = skip_reg - 31'd1;
                    if (skip_end)
                    begin
                        if (layer_end)
                        begin
                            layer_next = '0;
                            phase_next = PH_ENT_FLAG;
                        end
                        else
                        begin
                            layer_next = layer_reg + LCW'(1);
                            phase_next = PH_LIT_LTYPE;
                        end
                    end
                end
                PH_ENT_FLAG:
                    if (data_byte == ENT_BLOB)
                        phase_next = PH_ENT_SIZE;
                PH_ENT_SIZE:
                    if (word_done && !wlen_zero)
                    begin
                        skip_next  = wlen;
                        phase_next = PH_ENT_BYTES;
                    end
                PH_ENT_BYTES:
                    skip_next = skip_reg - 31'd1;
                default:
                    phase_next = PH_CX;
            endcase

            if (res_c.status != ST_OK)
                halted_next = 1'b1;

            // Drop back to the start of the next record
            if (res_c.record_last)
            begin
                phase_next = PH_CX;
                layer_next = '0;
                pal_next   = '0;
                skip_next  = '0;
                word_next  = '0;
                idx_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_CX;
            layer_reg  <= '0;
            pal_reg    <= '0;
            skip_reg   <= '0;
            word_reg   <= '0;
            idx_reg    <= '0;
            cx_reg     <= '0;
            cy_reg     <= '0;
            cz_reg     <= '0;
            halted_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            phase_reg  <= phase_next;
            layer_reg  <= layer_next;
            pal_reg    <= pal_next;
            skip_reg   <= skip_next;
            word_reg   <= word_next;
            idx_reg    <= idx_next;
            cx_reg     <= cx_next;
            cy_reg     <= cy_next;
            cz_reg     <= cz_next;
            halted_reg <= halted_next;
        end
    end

    // Output register with skid entry
    always_comb
    begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_fire || !out_valid_reg)
        begin
            out_next        = skid_valid_reg ? skid_reg : res_c;
            out_valid_next  = skid_valid_reg || in_fire;
            skid_valid_next = 1'b0;
        end
        else if (in_fire)
        begin
            skid_next       = res_c;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid   = out_valid_reg;
    assign byte_echo   = out_reg.byte_echo;
    assign section     = out_reg.section;
    assign record_last = out_reg.record_last;
    assign status      = out_reg.status;
    assign chunk_x     = out_reg.chunk_x;
    assign chunk_y     = out_reg.chunk_y;
    assign chunk_z     = out_reg.chunk_z;

endmodule

>>> sv/vcrp_checker.sv
// Port-level checks for the voxel chunk record parser, bound to its top level.
module vcrp_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic [7:0]         data_byte,
    input logic               out_valid,
    input logic               out_stall,
    input logic [7:0]         byte_echo,
    input logic [2:0]         section,
    input logic               record_last,
    input logic [3:0]         status,
    input logic signed [31:0] chunk_x,
    input logic signed [31:0] chunk_y,
    input logic signed [31:0] chunk_z
);
    import vcrp_pkg::*;

    logic err_seen_reg;
    logic err_seen_next;

    assign err_seen_next = err_seen_reg ||
        (out_valid && !out_stall && status != ST_OK && status != ST_HALTED);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            err_seen_reg <= 1'b0;
        else
            err_seen_reg <= err_seen_next;
    end

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(data_byte))
        else $error("stalled input transaction changed");

    a_last_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && record_last |-> status == ST_OK)
        else $error("record end reported with nonzero status");

    a_coords_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !record_last |-> chunk_x == 0 && chunk_y == 0 && chunk_z == 0)
        else $error("coordinates nonzero outside record end");

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        err_seen_reg && out_valid |->
            status == ST_HALTED && section == SEC_COORD && !record_last)
        else $error("transaction after an error not reported as halted");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(byte_echo) && $stable(status))
        else $error("stalled output transaction changed");

endmodule

bind voxel_chunk_record_parser_top vcrp_checker u_vcrp_checker (.*);

>>> test/voxel_chunk_record_parser_top_tb.sv
// Testbench for the voxel chunk record parser: directed and random chunk records, checked byte by byte.
module voxel_chunk_record_parser_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vcrp_pkg::*;

    localparam int LAYERS       = 16;
    localparam int LAYER_CELLS  = 256;
    localparam int RANDOM_BYTES = 120;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 4000;
    localparam int PRINT_LIMIT  = 40;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    logic [7:0]         data_byte = 8'd0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [7:0]         byte_echo;
    logic [2:0]         section;
    logic               record_last;
    logic [3:0]         status;
    logic signed [31:0] chunk_x;
    logic signed [31:0] chunk_y;
    logic signed [31:0] chunk_z;

    // parser state mirrored by the predictor
    phase_t      ph;
    int unsigned layer_cnt;
    logic [31:0] pal_left;
    logic [31:0] skip_left;
    logic [31:0] word_sh;
    logic [1:0]  word_idx;
    logic [31:0] coords [3];
    logic        halted;

    result_t     expected_results [$];
    logic [7:0]  record_bytes [$];
    int          mismatches   = 0;
    int          bytes_sent   = 0;
    int          records_seen = 0;
    int          burst_left   = 0;
    int          idle_cycles  = 0;
    int          hold_left    = 0;
    int          mode_left    = 0;
    logic        hold_req     = 1'b0;
    logic [3:0]  error_kind   = ST_OK;
    stall_mode_t stall_mode   = STALL_NONE;

    voxel_chunk_record_parser_top #(
        .LAYERS      (LAYERS),
        .LAYER_CELLS (LAYER_CELLS)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .byte_echo   (byte_echo),
        .section     (section),
        .record_last (record_last),
        .status      (status),
        .chunk_x     (chunk_x),
        .chunk_y     (chunk_y),
        .chunk_z     (chunk_z)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int blk_layer_len(input logic [7:0] t);
        int n;
        case (t)
            BL_ONE:     n = 1;
            BL_FOUR:    n = 4;
            BL_QUARTER: n = LAYER_CELLS / 4;
            BL_HALF:    n = LAYER_CELLS / 2;
            BL_FULL:    n = LAYER_CELLS;
            BL_DOUBLE:  n = LAYER_CELLS * 2;
            BL_EIGHTH:  n = LAYER_CELLS / 8;
            default:    n = 0;
        endcase
        return n;
    endfunction

    function automatic int sky_layer_len(input logic [7:0] t);
        int n;
        case (t)
            SKYL_ONE:  n = 1;
            SKYL_HALF: n = LAYER_CELLS / 2;
            default:   n = 0;
        endcase
        return n;
    endfunction

    function automatic int lit_layer_len(input logic [7:0] t);
        int n;
        if (t == LITL_THREE)
            n = 3;
        else if (t == LITL_DOUBLE)
            n = LAYER_CELLS * 2;
        else if (t >= LITL_MIX_LO && t <= LITL_MIX_HI)
            n = 3 + LAYER_CELLS / 2;
        else
            n = 0;
        return n;
    endfunction

    function automatic logic [2:0] section_for(input phase_t p);
        logic [2:0] s;
        case (p)
            PH_CX, PH_CY, PH_CZ:
                s = SEC_COORD;
            PH_BTYPE, PH_BSTR_LEN, PH_BSTR_BYTES, PH_PAL_SIZE, PH_PAL_LEN, PH_PAL_BYTES,
            PH_BL_LTYPE_BLK, PH_BLK_SKIP:
                s = SEC_BLOCK;
            PH_SKY_TYPE, PH_SKY_SKIP, PH_SKY_SINGLE, PH_SKY_LTYPE:
                s = SEC_SKY;
            PH_LIT_TYPE, PH_LIT_LTYPE, PH_LIT_SKIP:
                s = SEC_LIGHT;
            default:
                s = SEC_ENTITY;
        endcase
        return s;
    endfunction

    function automatic void reset_parser_model();
        ph        = PH_CX;
        layer_cnt = 0;
        pal_left  = '0;
        skip_left = '0;
        word_sh   = '0;
        word_idx  = '0;
        coords[0] = '0;
        coords[1] = '0;
        coords[2] = '0;
        halted    = 1'b0;
    endfunction

    function automatic logic take_word_byte(input logic [7:0] b);
        logic full;
        word_sh  = {word_sh[23:0], b};
        full     = (word_idx == 2'd3);
        word_idx = word_idx + 2'd1;
        return full;
    endfunction

    // negative or zero means nothing follows
    function automatic logic [31:0] word_count(input logic [31:0] w);
        return w[31] ? 32'd0 : w;
    endfunction

    function automatic void close_layer(input phase_t again, input phase_t after);
        layer_cnt++;
        if (layer_cnt >= LAYERS) begin
            layer_cnt = 0;
            ph = after;
        end
        else
            ph = again;
    endfunction

    function automatic void close_palette_string();
        pal_left--;
        if (pal_left == 0) begin
            layer_cnt = 0;
            ph = PH_BL_LTYPE_BLK;
        end
        else
            ph = PH_PAL_LEN;
    endfunction

    function automatic result_t parse_byte(input logic [7:0] b);
        result_t     r;
        logic [31:0] n;
        logic [3:0]  st;
        logic        done_rec;
        r = '0;
        r.byte_echo = b;
        if (halted) begin
            r.status = ST_HALTED;
            return r;
        end
        r.section = section_for(ph);
        st = ST_OK;
        done_rec = 1'b0;
        case (ph)
            PH_CX, PH_CY, PH_CZ:
                if (take_word_byte(b)) begin
                    coords[int'(ph)] = word_sh;
                    ph = phase_t'(ph + 1);
                end
            PH_BTYPE:
                if (b == BT_NULL)
                    ph = PH_SKY_TYPE;
                else if (b == BT_SINGLE)
                    ph = PH_BSTR_LEN;
                else if (b == BT_PALETTE)
                    ph = PH_PAL_SIZE;
                else
                    st = ST_BAD_BLOCK;
            PH_BSTR_LEN:
                if (take_word_byte(b)) begin
                    n = word_count(word_sh);
                    if (n == 0)
                        ph = PH_SKY_TYPE;
                    else begin
                        skip_left = n;
                        ph = PH_BSTR_BYTES;
                    end
                end
            PH_BSTR_BYTES:
            begin
                skip_left--;
                if (skip_left == 0)
                    ph = PH_SKY_TYPE;
            end
            PH_PAL_SIZE:
                if (take_word_byte(b)) begin
                    n = word_count(word_sh);
                    layer_cnt = 0;
                    if (n == 0)
                        ph = PH_BL_LTYPE_BLK;
                    else begin
                        pal_left = n;
                        ph = PH_PAL_LEN;
                    end
                end
            PH_PAL_LEN:
                if (take_word_byte(b)) begin
                    n = word_count(word_sh);
                    if (n == 0)
                        close_palette_string();
                    else begin
                        skip_left = n;
                        ph = PH_PAL_BYTES;
                    end
                end
            PH_PAL_BYTES:
            begin
                skip_left--;
                if (skip_left == 0)
                    close_palette_string();
            end
            PH_BL_LTYPE_BLK:
            begin
                n = blk_layer_len(b);
                if (n == 0)
                    st = ST_BAD_BLK_LAYER;
                else begin
                    skip_left = n;
                    ph = PH_BLK_SKIP;
                end
            end
            PH_BLK_SKIP:
            begin
                skip_left--;
                if (skip_left == 0)
                    close_layer(PH_BL_LTYPE_BLK, PH_SKY_TYPE);
            end
            PH_SKY_TYPE:
                if (b == SKY_NULL)
                    ph = PH_LIT_TYPE;
                else if (b == SKY_SINGLE)
                    ph = PH_SKY_SINGLE;
                else if (b == SKY_LAYERED) begin
                    layer_cnt = 0;
                    ph = PH_SKY_LTYPE;
                end
                else
                    st = ST_BAD_SKY;
            PH_SKY_SINGLE:
                ph = PH_LIT_TYPE;
            PH_SKY_LTYPE:
            begin
                n = sky_layer_len(b);
                if (n == 0)
                    st = ST_BAD_SKY_LAYER;
                else begin
                    skip_left = n;
                    ph = PH_SKY_SKIP;
                end
            end
            PH_SKY_SKIP:
            begin
                skip_left--;
                if (skip_left == 0)
                    close_layer(PH_SKY_LTYPE, PH_LIT_TYPE);
            end
            PH_LIT_TYPE:
                if (b == LIT_NULL)
                    ph = PH_ENT_FLAG;
                else if (b == LIT_LAYERED) begin
                    layer_cnt = 0;
                    ph = PH_LIT_LTYPE;
                end
                else
                    st = ST_BAD_LIGHT;
            PH_LIT_LTYPE:
            begin
                n = lit_layer_len(b);
                if (n == 0)
                    st = ST_BAD_LIT_LAYER;
                else begin
                    skip_left = n;
                    ph = PH_LIT_SKIP;
                end
            end
            PH_LIT_SKIP:
            begin
                skip_left--;
                if (skip_left == 0)
                    close_layer(PH_LIT_LTYPE, PH_ENT_FLAG);
            end
            PH_ENT_FLAG:
                if (b == ENT_NONE)
                    done_rec = 1'b1;
                else if (b == ENT_BLOB)
                    ph = PH_ENT_SIZE;
                else
                    st = ST_BAD_ENTITY;
            PH_ENT_SIZE:
                if (take_word_byte(b)) begin
                    n = word_count(word_sh);
                    if (n == 0)
                        done_rec = 1'b1;
                    else begin
                        skip_left = n;
                        ph = PH_ENT_BYTES;
                    end
                end
            PH_ENT_BYTES:
            begin
                skip_left--;
                if (skip_left == 0)
                    done_rec = 1'b1;
            end
            default:
                ph = PH_CX;
        endcase
        if (st != ST_OK)
            halted = 1'b1;
        r.status = st;
        r.record_last = done_rec;
        if (done_rec) begin
            r.chunk_x = coords[0];
            r.chunk_y = coords[1];
            r.chunk_z = coords[2];
            ph = PH_CX;
            layer_cnt = 0;
            pal_left = '0;
            skip_left = '0;
            word_sh = '0;
            word_idx = '0;
        end
        return r;
    endfunction

    function automatic logic [31:0] pick_coord();
        logic [31:0] c;
        case ($urandom_range(0, 7))
            0:       c = 32'h8000_0000;
            1:       c = 32'h7FFF_FFFF;
            2:       c = 32'h0000_0000;
            3:       c = 32'hFFFF_FFFF;
            default: c = $urandom;
        endcase
        return c;
    endfunction

    function automatic logic [31:0] pick_len();
        logic [31:0] len;
        case ($urandom_range(0, 9))
            0:       len = 32'h0000_0000;
            1:       len = 32'h8000_0000;
            2:       len = {1'b1, 31'($urandom)};
            default: len = $urandom_range(1, 6);
        endcase
        return len;
    endfunction

    function automatic logic [7:0] pick_blk_layer();
        int r;
        logic [7:0] t;
        r = $urandom_range(0, 99);
        if (r < 50)
            t = BL_ONE;
        else if (r < 85)
            t = BL_FOUR;
        else if (r < 98)
            t = BL_EIGHTH;
        else
            t = 8'($urandom_range(BL_QUARTER, BL_DOUBLE));
        return t;
    endfunction

    function automatic logic [7:0] pick_lit_layer();
        int r;
        logic [7:0] t;
        r = $urandom_range(0, 99);
        if (r < 95)
            t = LITL_THREE;
        else if (r < 97)
            t = LITL_DOUBLE;
        else
            t = 8'($urandom_range(LITL_MIX_LO, LITL_MIX_HI));
        return t;
    endfunction

    function automatic logic [7:0] bad_byte(input int first_bad, input logic zero_bad);
        logic [7:0] b;
        if (zero_bad && $urandom_range(0, 3) == 0)
            b = 8'd0;
        else
            b = 8'($urandom_range(first_bad, 255));
        return b;
    endfunction

    task automatic add_byte(input logic [7:0] b);
        record_bytes.insert(record_bytes.size(), b);
    endtask

    task automatic add_random_bytes(input int n);
        repeat (n) add_byte(8'($urandom));
    endtask

    task automatic add_word(input logic [31:0] w);
        for (int i = 3; i >= 0; i--)
            add_byte(w[8*i +: 8]);
    endtask

    task automatic add_string(input logic [31:0] len);
        add_word(len);
        if (!len[31])
            add_random_bytes(len);
    endtask

    task automatic add_layer(input logic [7:0] t, input int len);
        add_byte(t);
        add_random_bytes(len);
    endtask

    task automatic add_coords(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
        add_word(x);
        add_word(y);
        add_word(z);
    endtask

    task automatic add_plain_tail();
        add_byte(SKY_NULL);
        add_byte(LIT_NULL);
        add_byte(ENT_NONE);
    endtask

    task automatic send_byte(input logic [7:0] b);
        int gap;
        result_t r;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        data_byte <= b;
        do
            @(posedge clk);
        while (in_stall);
        r = parse_byte(b);
        expected_results.insert(expected_results.size(), r);
        bytes_sent++;
        burst_left--;
    endtask

    task automatic send_queued();
        while (record_bytes.size() != 0)
            send_byte(record_bytes.pop_front());
    endtask

    task automatic build_random_record();
        logic [31:0] pal;
        logic [7:0]  t;
        int          sel;
        add_coords(pick_coord(), pick_coord(), pick_coord());
        sel = $urandom_range(0, 19);
        if (sel < 8)
            add_byte(BT_NULL);
        else if (sel < 15) begin
            add_byte(BT_SINGLE);
            add_string(pick_len());
        end
        else begin
            add_byte(BT_PALETTE);
            pal = pick_len();
            add_word(pal);
            if (!pal[31])
                repeat (pal) add_string(pick_len());
            repeat (LAYERS) begin
                t = pick_blk_layer();
                add_layer(t, blk_layer_len(t));
            end
        end
        sel = $urandom_range(0, 19);
        if (sel < 7)
            add_byte(SKY_NULL);
        else if (sel < 14) begin
            add_byte(SKY_SINGLE);
            add_random_bytes(1);
        end
        else begin
            add_byte(SKY_LAYERED);
            repeat (LAYERS) begin
                t = ($urandom_range(0, 32) == 0) ? SKYL_HALF : SKYL_ONE;
                add_layer(t, sky_layer_len(t));
            end
        end
        if ($urandom_range(0, 4) < 3)
            add_byte(LIT_NULL);
        else begin
            add_byte(LIT_LAYERED);
            repeat (LAYERS) begin
                t = pick_lit_layer();
                add_layer(t, lit_layer_len(t));
            end
        end
        if ($urandom_range(0, 1) == 0)
            add_byte(ENT_NONE);
        else begin
            add_byte(ENT_BLOB);
            add_string(pick_len());
        end
    endtask

    task automatic test_coordinate_extremes();
        add_coords(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        add_byte(BT_NULL);
        add_plain_tail();
        add_coords(32'h0000_0000, 32'h0000_0001, 32'h89AB_CDEF);
        add_byte(BT_NULL);
        add_byte(SKY_SINGLE);
        add_byte(8'hFF);
        add_byte(LIT_NULL);
        add_byte(ENT_BLOB);
        add_string(32'h8000_0000);
        add_coords(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
        add_byte(BT_NULL);
        add_byte(SKY_NULL);
        add_byte(LIT_NULL);
        add_byte(ENT_BLOB);
        add_string(32'h0000_0000);
        add_coords(32'h0102_0304, 32'hFEDC_BA98, 32'h5555_AAAA);
        add_byte(BT_NULL);
        add_byte(SKY_NULL);
        add_byte(LIT_NULL);
        add_byte(ENT_BLOB);
        add_string(32'd3);
        send_queued();
    endtask

    task automatic test_block_strings();
        add_coords(pick_coord(), pick_coord(), pick_coord());
        add_byte(BT_SINGLE);
        add_string(32'd5);
        add_plain_tail();
        add_coords(pick_coord(), pick_coord(), pick_coord());
        add_byte(BT_SINGLE);
        add_string(32'd0);
        add_plain_tail();
        add_coords(pick_coord(), pick_coord(), pick_coord());
        add_byte(BT_SINGLE);
        add_string(32'hFFFF_FFFF);
        add_plain_tail();
        add_coords(pick_coord(), pick_coord(), pick_coord());
        add_byte(BT_PALETTE);
        add_word(32'd0);
        repeat (LAYERS) add_layer(BL_ONE, 1);
        add_plain_tail();
        add_coords(pick_coord(), pick_coord(), pick_coord());
        add_byte(BT_PALETTE);
        add_word(32'h8000_0001);
        repeat (LAYERS) add_layer(BL_FOUR, 4);
        add_plain_tail();
        send_queued();
    endtask

    task automatic test_layer_types();
        logic [7:0] t;
        add_coords(pick_coord(), pick_coord(), pick_coord());
        add_byte(BT_PALETTE);
        add_word(32'd3);
        add_string(32'd2);
        add_string(32'd0);
        add_string(32'h8000_0000);
        for (int i = 0; i < LAYERS; i++) begin
            t = (i <= BL_EIGHTH - BL_ONE) ? 8'(BL_ONE + i) : BL_ONE;
            if (t == BL_DOUBLE)
                t = BL_ONE;
            add_layer(t, blk_layer_len(t));
        end
        add_byte(SKY_LAYERED);
        for (int i = 0; i < LAYERS; i++) begin
            t = (i == 0) ? SKYL_HALF : SKYL_ONE;
            add_layer(t, sky_layer_len(t));
        end
        add_byte(LIT_LAYERED);
        for (int i = 0; i < LAYERS; i++) begin
            t = (i <= LITL_MIX_HI - LITL_THREE) ? 8'(LITL_THREE + i) : LITL_THREE;
            if (t == LITL_DOUBLE)
                t = LITL_THREE;
            add_layer(t, lit_layer_len(t));
        end
        add_byte(ENT_BLOB);
        add_string(32'd1);
        send_queued();
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        build_random_record();
        send_queued();
    endtask

    task automatic test_random_records();
        int start;
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_BYTES) begin
            build_random_record();
            send_queued();
        end
    endtask

    task automatic test_error_halt();
        logic [3:0] kind;
        kind = 4'($urandom_range(ST_BAD_BLOCK, ST_BAD_ENTITY));
        error_kind = kind;
        add_coords(pick_coord(), pick_coord(), pick_coord());
        case (kind)
            ST_BAD_BLOCK:
                add_byte(bad_byte(BT_PALETTE + 1, 1'b0));
            ST_BAD_BLK_LAYER:
            begin
                add_byte(BT_PALETTE);
                add_word(32'd0);
                repeat ($urandom_range(0, 3)) add_layer(BL_ONE, 1);
                add_byte(bad_byte(BL_EIGHTH + 1, 1'b1));
            end
            ST_BAD_SKY:
            begin
                add_byte(BT_NULL);
                add_byte(bad_byte(SKY_SINGLE + 1, 1'b1));
            end
            ST_BAD_SKY_LAYER:
            begin
                add_byte(BT_NULL);
                add_byte(SKY_LAYERED);
                repeat ($urandom_range(0, 3)) add_layer(SKYL_ONE, 1);
                add_byte(bad_byte(SKYL_HALF + 1, 1'b1));
            end
            ST_BAD_LIGHT:
            begin
                add_byte(BT_NULL);
                add_byte(SKY_NULL);
                add_byte(bad_byte(LIT_LAYERED + 1, 1'b1));
            end
            ST_BAD_LIT_LAYER:
            begin
                add_byte(BT_NULL);
                add_byte(SKY_NULL);
                add_byte(LIT_LAYERED);
                repeat ($urandom_range(0, 3)) add_layer(LITL_THREE, 3);
                add_byte(bad_byte(LITL_MIX_HI + 1, 1'b1));
            end
            default:
            begin
                add_byte(BT_NULL);
                add_byte(SKY_NULL);
                add_byte(LIT_NULL);
                add_byte(bad_byte(ENT_BLOB + 1, 1'b0));
            end
        endcase
        add_random_bytes($urandom_range(16, 40));
        send_queued();
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= PRINT_LIMIT)
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= PRINT_LIMIT)
                    $display("%0t: result with no byte pending, expected none actual byte_echo %0h",
                             $time, byte_echo);
            end
            else begin
                want = expected_results.pop_front();
                compare_field("byte_echo", 32'(want.byte_echo), 32'(byte_echo));
                compare_field("section", 32'(want.section), 32'(section));
                compare_field("record_last", 32'(want.record_last), 32'(record_last));
                compare_field("status", 32'(want.status), 32'(status));
                compare_field("chunk_x", want.chunk_x, chunk_x);
                compare_field("chunk_y", want.chunk_y, chunk_y);
                compare_field("chunk_z", want.chunk_z, chunk_z);
                if (want.record_last)
                    records_seen++;
            end
        end
    end

    // hold off completely on request, otherwise stall in random modes
    always @(negedge clk)
    begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else begin
            if (mode_left == 0) begin
                stall_mode = stall_mode_t'($urandom_range(STALL_NONE, STALL_HEAVY));
                mode_left = $urandom_range(16, 160);
            end
            else
                mode_left--;
            case (stall_mode)
                STALL_NONE:  out_stall <= 1'b0;
                STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                default:     out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("Mismatches found");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        reset_parser_model();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_coordinate_extremes();
        test_block_strings();
        test_layer_types();
        test_backpressure();
        test_random_records();
        test_error_halt();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        $display("Covered %0d bytes and %0d complete records, including a long output hold.",
                 bytes_sent, records_seen);
        $display("Stream ended on error code %0d followed by halted bytes.", error_kind);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
